[rtl/ll1tb_pkg.sv]
package ll1tb_pkg;

    localparam int NT_MAX     = 8;
    localparam int ALT_MAX    = 4;
    localparam int LEN_MAX    = 8;
    localparam int SYM_DEPTH  = NT_MAX * ALT_MAX * LEN_MAX;
    localparam int SYM_AW     = 8;
    localparam int END_COL    = 8;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_BUILD = 2'd2;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_NTCNT = 2'd1;
    localparam logic [1:0] REG_TCNT  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] head;
        logic [1:0] alternative;
        logic [2:0] position;
        logic       symbol_is_nonterminal;
        logic [2:0] symbol_index;
        logic [3:0] alternative_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  row_nonterminal;
        logic [7:0]  first_bits;
        logic        is_nullable;
        logic [8:0]  follow_bits;
        logic [8:0]  table_valid_bits;
        logic [17:0] table_alternatives;
        logic        has_conflict;
        logic        last_row;
    } out_item_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SLOT = 6'b000010,
        ST_RD   = 6'b000100,
        ST_EV   = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_ROW  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_FOLLOW = 3'b010,
        PH_TABLE  = 3'b100
    } phase_t;

    function automatic logic [3:0] clamp_count(input logic [3:0] v);
        if (v == 4'd0) begin
            return 4'd1;
        end else if (v > 4'd8) begin
            return 4'd8;
        end
        return v;
    endfunction

endpackage

[rtl/ll1tb_ram.sv]
module ll1tb_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ll1_table_builder_unit.sv]
// Clear and symbol-write beats are taken while idle and may arrive back to back.
// A build beat runs FIRST/nullable sweeps, then FOLLOW sweeps, each repeated until a sweep
// changes nothing, then one table pass. For a present alternative slot each rule symbol is
// read from the symbol RAM and evaluated (the FIRST and table passes stop at a non-nullable
// one and end with a finish step). One row per nonterminal follows, as m_ready allows.
// Reset (aresetn low, synchronous) resets control and config (start 0, counts 1), clears the rule flags and lengths.
module ll1_table_builder_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ll1tb_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ll1tb_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [3:0]           cfg_data
);

    ll1tb_pkg::state_t state_reg, state_next;
    ll1tb_pkg::phase_t phase_reg, phase_next;

    logic [2:0]  start_reg;
    logic [3:0]  ntcnt_reg, tcnt_reg;
    logic [31:0] present_reg, present_next;
    logic [3:0]  len_reg [32];
    logic [3:0]  len_next [32];
    logic [7:0]  first_reg [8];
    logic [7:0]  first_next [8];
    logic [7:0]  nullable_reg, nullable_next;
    logic [8:0]  follow_reg [8];
    logic [8:0]  follow_next [8];

    logic [2:0]  h_reg, h_next;
    logic [1:0]  a_reg, a_next;
    logic [2:0]  p_reg, p_next;
    logic [7:0]  acc_reg, acc_next;
    logic        nul_reg, nul_next;
    logic        changed_reg, changed_next;
    logic [8:0]  vbits_reg, vbits_next;
    logic [17:0] alts_reg, alts_next;
    logic        conflict_reg, conflict_next;

    logic                 m_valid_reg, m_valid_next;
    ll1tb_pkg::out_item_t m_data_reg, m_data_next;

    logic [3:0] nc, tc;
    logic [4:0] slot;
    logic [3:0] cur_len;
    logic       s_fire;
    logic       ram_we;
    logic [7:0] ram_waddr, ram_raddr;
    logic [3:0] ram_wdata, sym;
    logic       sym_nt;
    logic [2:0] sym_idx;
    logic       nt_ok, t_ok;
    logic       last_h;
    logic       adv;
    logic [8:0] cols, fadd;

    assign nc      = ll1tb_pkg::clamp_count(ntcnt_reg);
    assign tc      = ll1tb_pkg::clamp_count(tcnt_reg);
    assign slot    = {h_reg, a_reg};
    assign cur_len = len_reg[slot];
    assign s_ready = (state_reg == ll1tb_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign ram_we    = s_fire && (s_data.mode == ll1tb_pkg::MODE_WRITE);
    assign ram_waddr = {s_data.head, s_data.alternative, s_data.position};
    assign ram_wdata = {s_data.symbol_is_nonterminal, s_data.symbol_index};
    assign ram_raddr = {h_reg, a_reg, p_reg};

    ll1tb_ram #(.WIDTH(4), .DEPTH(ll1tb_pkg::SYM_DEPTH)) u_sym_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (sym)
    );

    assign sym_nt  = sym[3];
    assign sym_idx = sym[2:0];
    assign nt_ok   = ({1'b0, sym_idx} < nc);
    assign t_ok    = ({1'b0, sym_idx} < tc);
    assign last_h  = (({1'b0, h_reg} + 4'd1) == nc);
    assign cols    = {1'b0, acc_reg} | (nul_reg ? follow_reg[h_reg] : 9'd0);
    assign fadd    = {1'b0, acc_reg} | (nul_reg ? follow_reg[h_reg] : 9'd0);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        present_next  = present_reg;
        len_next      = len_reg;
        first_next    = first_reg;
        nullable_next = nullable_reg;
        follow_next   = follow_reg;
        h_next        = h_reg;
        a_next        = a_reg;
        p_next        = p_reg;
        acc_next      = acc_reg;
        nul_next      = nul_reg;
        changed_next  = changed_reg;
        vbits_next    = vbits_reg;
        alts_next     = alts_reg;
        conflict_next = conflict_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        adv           = 1'b0;

        case (state_reg)
            ll1tb_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.mode)
                        ll1tb_pkg::MODE_CLEAR: begin
                            present_next = '0;
                            for (int i = 0; i < 32; i++) begin
                                len_next[i] = 4'd0;
                            end
                        end
                        ll1tb_pkg::MODE_WRITE: begin
                            present_next[{s_data.head, s_data.alternative}] = 1'b1;
                            len_next[{s_data.head, s_data.alternative}] =
                                (s_data.alternative_length > 4'd8) ? 4'd8
                                                                   : s_data.alternative_length;
                        end
                        ll1tb_pkg::MODE_BUILD: begin
                            for (int i = 0; i < 8; i++) begin
                                first_next[i]  = 8'd0;
                                follow_next[i] = 9'd0;
                            end
                            nullable_next = 8'd0;
                            phase_next    = ll1tb_pkg::PH_FIRST;
                            h_next        = 3'd0;
                            a_next        = 2'd0;
                            changed_next  = 1'b0;
                            state_next    = ll1tb_pkg::ST_SLOT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ll1tb_pkg::ST_SLOT: begin
                acc_next = 8'd0;
                nul_next = 1'b1;
                if (!present_reg[slot]) begin
                    adv = 1'b1;
                end else if (phase_reg == ll1tb_pkg::PH_FOLLOW) begin
                    if (cur_len == 4'd0) begin
                        adv = 1'b1;
                    end else begin
                        p_next     = 3'(cur_len - 4'd1);
                        state_next = ll1tb_pkg::ST_RD;
                    end
                end else begin
                    p_next     = 3'd0;
                    state_next = (cur_len == 4'd0) ? ll1tb_pkg::ST_FIN : ll1tb_pkg::ST_RD;
                end
            end
            ll1tb_pkg::ST_RD: begin
                state_next = ll1tb_pkg::ST_EV;
            end
            ll1tb_pkg::ST_EV: begin
                if (phase_reg == ll1tb_pkg::PH_FOLLOW) begin
                    // walk right to left, acc/nul hold FIRST and nullability of the suffix
                    if (sym_nt && nt_ok) begin
                        if ((follow_reg[sym_idx] | fadd) != follow_reg[sym_idx]) begin
                            changed_next = 1'b1;
                        end
                        follow_next[sym_idx] = follow_reg[sym_idx] | fadd;
                        acc_next = first_reg[sym_idx] | (nullable_reg[sym_idx] ? acc_reg : 8'd0);
                        nul_next = nullable_reg[sym_idx] && nul_reg;
                    end else if (sym_nt) begin
                        acc_next = 8'd0;
                        nul_next = 1'b0;
                    end else begin
                        acc_next = t_ok ? (8'd1 << sym_idx) : 8'd0;
                        nul_next = 1'b0;
                    end
                    if (p_reg == 3'd0) begin
                        adv = 1'b1;
                    end else begin
                        p_next     = p_reg - 3'd1;
                        state_next = ll1tb_pkg::ST_RD;
                    end
                end else begin
                    state_next = ll1tb_pkg::ST_FIN;
                    if (sym_nt && nt_ok) begin
                        acc_next = acc_reg | first_reg[sym_idx];
                        if (!nullable_reg[sym_idx]) begin
                            nul_next = 1'b0;
                        end else if ({1'b0, p_reg} != cur_len - 4'd1) begin
                            p_next     = p_reg + 3'd1;
                            state_next = ll1tb_pkg::ST_RD;
                        end
                    end else if (sym_nt) begin
                        nul_next = 1'b0;
                    end else begin
                        acc_next = acc_reg | (t_ok ? (8'd1 << sym_idx) : 8'd0);
                        nul_next = 1'b0;
                    end
                end
            end
            ll1tb_pkg::ST_FIN: begin
                adv = 1'b1;
                if (phase_reg == ll1tb_pkg::PH_FIRST) begin
                    if (((first_reg[h_reg] | acc_reg) != first_reg[h_reg]) ||
                        (nul_reg && !nullable_reg[h_reg])) begin
                        changed_next = 1'b1;
                    end
                    first_next[h_reg] = first_reg[h_reg] | acc_reg;
                    if (nul_reg) begin
                        nullable_next[h_reg] = 1'b1;
                    end
                end else begin
                    for (int c = 0; c <= ll1tb_pkg::END_COL; c++) begin
                        if (cols[c]) begin
                            if (vbits_reg[c]) begin
                                conflict_next = 1'b1;
                            end else begin
                                vbits_next[c]       = 1'b1;
                                alts_next[2*c +: 2] = a_reg;
                            end
                        end
                    end
                end
            end
            ll1tb_pkg::ST_ROW: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.row_nonterminal    = h_reg;
                    m_data_next.first_bits         = first_reg[h_reg];
                    m_data_next.is_nullable        = nullable_reg[h_reg];
                    m_data_next.follow_bits        = follow_reg[h_reg];
                    m_data_next.table_valid_bits   = vbits_reg;
                    m_data_next.table_alternatives = alts_reg;
                    m_data_next.has_conflict       = conflict_reg;
                    m_data_next.last_row           = last_h;
                    vbits_next    = 9'd0;
                    alts_next     = 18'd0;
                    conflict_next = 1'b0;
                    a_next        = 2'd0;
                    if (last_h) begin
                        state_next = ll1tb_pkg::ST_IDLE;
                    end else begin
                        h_next     = h_reg + 3'd1;
                        state_next = ll1tb_pkg::ST_SLOT;
                    end
                end
            end
            default: begin
                state_next = ll1tb_pkg::ST_IDLE;
            end
        endcase

        if (adv) begin
            state_next = ll1tb_pkg::ST_SLOT;
            if (a_reg != 2'd3) begin
                a_next = a_reg + 2'd1;
            end else if (phase_reg == ll1tb_pkg::PH_TABLE) begin
                state_next = ll1tb_pkg::ST_ROW;
            end else if (!last_h) begin
                a_next = 2'd0;
                h_next = h_reg + 3'd1;
            end else begin
                // end of a sweep: repeat it, or move on to the next phase
                a_next = 2'd0;
                h_next = 3'd0;
                if (changed_next) begin
                    phase_next = phase_reg;
                end else if (phase_reg == ll1tb_pkg::PH_FIRST) begin
                    phase_next = ll1tb_pkg::PH_FOLLOW;
                    if ({1'b0, start_reg} < nc) begin
                        follow_next[start_reg][ll1tb_pkg::END_COL] = 1'b1;
                    end
                end else begin
                    phase_next    = ll1tb_pkg::PH_TABLE;
                    vbits_next    = 9'd0;
                    alts_next     = 18'd0;
                    conflict_next = 1'b0;
                end
                changed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ll1tb_pkg::ST_IDLE;
            phase_reg    <= ll1tb_pkg::PH_FIRST;
            start_reg    <= 3'd0;
            ntcnt_reg    <= 4'd1;
            tcnt_reg     <= 4'd1;
            present_reg  <= '0;
            m_valid_reg  <= 1'b0;
            changed_reg  <= 1'b0;
            nullable_reg <= 8'd0;
            for (int i = 0; i < 32; i++) begin
                len_reg[i] <= 4'd0;
            end
            for (int i = 0; i < 8; i++) begin
                first_reg[i]  <= 8'd0;
                follow_reg[i] <= 9'd0;
            end
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            present_reg  <= present_next;
            len_reg      <= len_next;
            first_reg    <= first_next;
            nullable_reg <= nullable_next;
            follow_reg   <= follow_next;
            changed_reg  <= changed_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    ll1tb_pkg::REG_START: start_reg <= cfg_data[2:0];
                    ll1tb_pkg::REG_NTCNT: ntcnt_reg <= cfg_data;
                    ll1tb_pkg::REG_TCNT:  tcnt_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        h_reg        <= h_next;
        a_reg        <= a_next;
        p_reg        <= p_next;
        acc_reg      <= acc_next;
        nul_reg      <= nul_next;
        vbits_reg    <= vbits_next;
        alts_reg     <= alts_next;
        conflict_reg <= conflict_next;
        m_data_reg   <= m_data_next;
    end

endmodule
